@@ rtl/pse_pkg.sv @@
// Shared constants, status codes and decode helpers for the postfix stack evaluator.
package pse_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int SYM_W       = 8;
  localparam int STATUS_W    = 3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

  localparam logic [SYM_W-1:0] CH_ZERO   = 8'd48;
  localparam logic [SYM_W-1:0] DIGIT_MAX = 8'd9;
  localparam logic [SYM_W-1:0] OP_ADD    = 8'h2B;
  localparam logic [SYM_W-1:0] OP_SUB    = 8'h2D;
  localparam logic [SYM_W-1:0] OP_MUL    = 8'h2A;
  localparam logic [SYM_W-1:0] OP_DIV    = 8'h2F;
  localparam logic [SYM_W-1:0] OP_MOD    = 8'h25;

  function automatic logic is_digit(input logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] off;
    off = sym - CH_ZERO;
    return (sym >= CH_ZERO) && (off <= DIGIT_MAX);
  endfunction

  function automatic logic is_oper(input logic [SYM_W-1:0] sym);
    return (sym == OP_ADD) || (sym == OP_SUB) || (sym == OP_MUL) ||
           (sym == OP_DIV) || (sym == OP_MOD);
  endfunction

  // First error of an expression wins.
  function automatic logic [STATUS_W-1:0] sticky(input logic [STATUS_W-1:0] cur,
                                                 input logic [STATUS_W-1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

@@ rtl/pse_in_if.sv @@
// Input channel: one ASCII symbol per transaction, with an end-of-expression mark.
interface pse_in_if;
  logic                       valid;
  logic                       ready;
  logic [pse_pkg::SYM_W-1:0]  symbol;
  logic                       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

@@ rtl/pse_out_if.sv @@
// Result channel: expression value and status, one transaction per expression.
interface pse_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [pse_pkg::DATA_W-1:0]   value;
  logic [pse_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ rtl/pse_stack_mem.sv @@
// Operand stack storage: one write port, one read port, registered read data.
module pse_stack_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [pse_pkg::ADDR_W-1:0]  waddr,
  input  logic [pse_pkg::DATA_W-1:0]  wdata,
  input  logic                        re,
  input  logic [pse_pkg::ADDR_W-1:0]  raddr,
  output logic [pse_pkg::DATA_W-1:0]  rdata
);

  logic [pse_pkg::DATA_W-1:0] mem_r [pse_pkg::STACK_DEPTH];
  logic [pse_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pse_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module pse_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pse_pkg::DATA_W-1:0]  dividend,
  input  logic [pse_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [pse_pkg::DATA_W-1:0]  quotient,
  output logic [pse_pkg::DATA_W-1:0]  remainder
);

  localparam int DW = pse_pkg::DATA_W;

  logic                          busy_r;
  logic                          done_r;
  logic [pse_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [DW-1:0]                 quo_r;
  logic [DW-1:0]                 rem_r;
  logic [DW-1:0]                 dvs_r;
  logic [DW:0]                   shifted;
  logic [DW:0]                   diff;
  logic                          fits;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pse_pkg::DIV_CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below the divisor, so DW bits hold it
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/postfix_stack_evaluator.sv @@
// Postfix (RPN) expression evaluator: top level with stack sequencer and result register.
//
// Usage:
//   in_chan takes one ASCII symbol per transaction. A digit '0'..'9' is pushed;
//   + - * / % pop the right then the left operand and push the result. Any other
//   symbol is ignored and marks the expression bad. The transaction with last=1
//   closes the expression: one transaction on out_chan carries the top of stack
//   and the first error seen (0 ok, 1 underflow, 2 divide by zero, 3 overflow,
//   4 bad symbol). Stack and status are then cleared for the next expression.
// Sequencing, from acceptance to the next possible acceptance on in_chan:
//   digit or bad symbol: S_DONE; + and -: S_OP, S_DONE; *: S_OP, S_MUL, S_DONE;
//   / and %: S_OP, S_DIV (the divider takes one quotient bit per cycle), S_DONE;
//   / and % by zero: S_OP, S_DONE. The stack memory read of the left operand is
//   issued as every operator is accepted. A closing transaction's result appears
//   on out_chan the cycle after S_DONE loads it. Only one symbol is in flight at a time.
// Stalls: the result sits in an output register; later symbols keep flowing
//   while it waits, and only the next closing symbol holds until it is taken.
// Reset (rst_n, synchronous, active low): empty stack, status ok, no result
//   pending. Stack memory contents are not cleared; only written entries are read.
module postfix_stack_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  pse_in_if.sink      in_chan,
  pse_out_if.source   out_chan
);

  localparam int DW    = pse_pkg::DATA_W;
  localparam int CNT_W = pse_pkg::CNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [pse_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [DW-1:0]                   top_r, top_nxt;        // top of stack lives here
  logic [DW-1:0]                   opa_r, opa_nxt;        // left operand
  logic [DW-1:0]                   opb_r, opb_nxt;        // right operand
  logic [pse_pkg::SYM_W-1:0]       sym_r;
  logic                            last_r;

  logic                            out_valid_r;
  logic [DW-1:0]                   out_value_r;
  logic [pse_pkg::STATUS_W-1:0]    out_status_r;
  logic                            load_out;
  logic [DW-1:0]                   fin_value;
  logic [pse_pkg::STATUS_W-1:0]    fin_status;

  logic                            in_fire;
  logic [CNT_W-1:0]                cnt_m1, cnt_m2;

  logic                            mem_we, mem_re;
  logic [pse_pkg::ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [DW-1:0]                   mem_rdata;

  logic [DW-1:0]                   op_left, op_right, op_sum, op_diff;
  logic [DW-1:0]                   mag_a, mag_b;
  logic signed [2*DW-1:0]          prod;
  logic                            div_start, div_done, div_neg;
  logic [DW-1:0]                   div_quo, div_rem;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // entries below the top live in memory at 0 .. count-2
  assign cnt_m1    = count_r - CNT_W'(1);
  assign cnt_m2    = count_r - CNT_W'(2);
  assign mem_waddr = cnt_m1[pse_pkg::ADDR_W-1:0];
  assign mem_raddr = cnt_m2[pse_pkg::ADDR_W-1:0];

  // a pop from an empty stack reads zero
  assign op_right = (count_r != '0) ? top_r : '0;
  assign op_left  = (count_r >= CNT_W'(2)) ? mem_rdata : '0;
  assign op_sum   = op_left + op_right;
  assign op_diff  = op_left - op_right;
  assign mag_a    = op_left[DW-1]  ? ({DW{1'b0}} - op_left)  : op_left;
  assign mag_b    = op_right[DW-1] ? ({DW{1'b0}} - op_right) : op_right;
  assign prod     = $signed(opa_r) * $signed(opb_r);
  assign div_neg  = opa_r[DW-1] ^ opb_r[DW-1];

  assign fin_value  = (count_r == '0) ? '0 : top_r;
  assign fin_status = (count_r == '0) ? pse_pkg::sticky(status_r, pse_pkg::ST_UNDER)
                                      : status_r;

  pse_stack_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (top_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pse_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_a),
    .divisor   (mag_b),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    top_nxt    = top_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          if (pse_pkg::is_digit(in_chan.symbol)) begin
            if (count_r == CNT_W'(pse_pkg::STACK_DEPTH)) begin
              status_nxt = pse_pkg::sticky(status_r, pse_pkg::ST_OVER);
            end else begin
              // spill old top to memory, digit becomes new top
              mem_we    = (count_r != '0);
              top_nxt   = {{(DW-pse_pkg::SYM_W){1'b0}},
                           in_chan.symbol - pse_pkg::CH_ZERO};
              count_nxt = count_r + CNT_W'(1);
            end
            state_nxt = S_DONE;
          end else if (pse_pkg::is_oper(in_chan.symbol)) begin
            mem_re    = 1'b1;
            state_nxt = S_OP;
          end else begin
            status_nxt = pse_pkg::sticky(status_r, pse_pkg::ST_BAD);
            state_nxt  = S_DONE;
          end
        end
      end
      S_OP: begin
        if (count_r < CNT_W'(2)) begin
          status_nxt = pse_pkg::sticky(status_r, pse_pkg::ST_UNDER);
        end
        count_nxt = (count_r >= CNT_W'(2)) ? cnt_m1 : CNT_W'(1);
        opa_nxt   = op_left;
        opb_nxt   = op_right;
        state_nxt = S_DONE;
        case (sym_r)
          pse_pkg::OP_ADD: begin
            top_nxt = op_sum;
            if ((op_left[DW-1] == op_right[DW-1]) && (op_sum[DW-1] != op_left[DW-1])) begin
              status_nxt = pse_pkg::sticky(status_nxt, pse_pkg::ST_OVER);
            end
          end
          pse_pkg::OP_SUB: begin
            top_nxt = op_diff;
            if ((op_left[DW-1] != op_right[DW-1]) && (op_diff[DW-1] != op_left[DW-1])) begin
              status_nxt = pse_pkg::sticky(status_nxt, pse_pkg::ST_OVER);
            end
          end
          pse_pkg::OP_MUL: begin
            state_nxt = S_MUL;
          end
          default: begin
            // divide and modulo
            if (op_right == '0) begin
              status_nxt = pse_pkg::sticky(status_nxt, pse_pkg::ST_DIVZERO);
              top_nxt    = '0;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_MUL: begin
        top_nxt = prod[DW-1:0];
        // out of range unless the upper half is the sign extension
        if (prod[2*DW-1:DW-1] != {(DW+1){prod[DW-1]}}) begin
          status_nxt = pse_pkg::sticky(status_r, pse_pkg::ST_OVER);
        end
        state_nxt = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          if (sym_r == pse_pkg::OP_DIV) begin
            top_nxt = div_neg ? ({DW{1'b0}} - div_quo) : div_quo;
            if (!div_neg && div_quo[DW-1]) begin
              status_nxt = pse_pkg::sticky(status_r, pse_pkg::ST_OVER);
            end
          end else begin
            // remainder follows the sign of the left operand
            top_nxt = opa_r[DW-1] ? ({DW{1'b0}} - div_rem) : div_rem;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_chan.ready) begin
          load_out   = 1'b1;
          count_nxt  = '0;
          status_nxt = pse_pkg::ST_OK;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      status_r    <= pse_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    if (in_fire) begin
      sym_r  <= in_chan.symbol;
      last_r <= in_chan.last;
    end
    if (load_out) begin
      out_value_r  <= fin_value;
      out_status_r <= fin_status;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.value  = out_value_r;
  assign out_chan.status = out_status_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(pse_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide wait");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past((state_r == S_DONE) && last_r))
    else $error("result issued without closing symbol");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> ((count_r == '0) && (status_r == pse_pkg::ST_OK)))
    else $error("stack or status not cleared after result");
`endif

endmodule
